// File: sv/psd3_pkg.sv
// Shared types, codes and helpers for the 3x3 pixel spike detector.
`default_nettype none
package psd3_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_LOCAL_FACTOR = 2'd1;
  localparam logic [1:0] REG_Z_LIMIT      = 2'd2;
  localparam logic [1:0] REG_GLOBAL_FLOOR = 2'd3;

  localparam int unsigned MUL_W = 24;

  typedef struct packed {
    logic [15:0] pixel;
    logic        frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] center_column;
    logic       local_spike;
    logic       hybrid_spike;
  } result_t;

  // Operation issued to the shared multiplier in a given cycle.
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_FL   = 4'd1,
    OP_FZ   = 4'd2,
    OP_SQ   = 4'd3,
    OP_SS   = 4'd4,
    OP_DD   = 4'd5,
    OP_LLO  = 4'd6,
    OP_LHI  = 4'd7,
    OP_ZLO  = 4'd8,
    OP_ZHI  = 4'd9
  } op_e;

  typedef struct packed {
    logic       accept;
    logic       shift;
    op_e        op;
    logic [2:0] idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic out_free;
  } status_t;

  // Window position of neighbour number idx; the centre (position 4) is skipped.
  function automatic logic [3:0] nb_pos(input logic [2:0] idx);
    logic [3:0] p;
    p = {1'b0, idx};
    if (idx >= 3'd4) begin
      p = p + 4'd1;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: sv/pixel_spike_detect_3x3.sv
// Top level of the streaming 3x3 pixel spike detector.
`default_nettype none
// Pixels enter in raster order, one request per pixel, with frame_start marking
// the first pixel of a frame. Two line stores in single-port RAM keep the two
// previous rows, and a 3x3 window slides along the row. Once two full rows of
// the frame are in and the column is at least two, the pixel one row up and one
// column left is classified against its eight neighbours, and one result
// request comes out; other pixels give no result. Each pixel is handled on its
// own: each pixel is accepted, then the line stores are read and written back;
// a pixel that gives a result then runs the 17 steps of the one shared 24x24
// multiplier that forms the squares, the variance and the scaled comparisons,
// then waits for the result register to be free and loads it. The result
// register lets the next pixel be accepted while a result still waits to be
// taken. Both spike tests are exact integer comparisons of squared quantities.
// Configuration is written through the APB port while the block is idle; the
// user must keep to that, as the block does not enforce it. pready is always high.
module pixel_spike_detect_3x3 #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire psd3_pkg::pixel_in_t in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output psd3_pkg::result_t        out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  // Configuration registers.
  logic [8:0]  line_width_q;
  logic [7:0]  local_factor_q;
  logic [7:0]  z_limit_q;
  logic [15:0] global_floor_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= 9'd256;
      local_factor_q <= 8'd12;
      z_limit_q      <= 8'd14;
      global_floor_q <= 16'd0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        psd3_pkg::REG_LINE_WIDTH:   line_width_q   <= pwdata[8:0];
        psd3_pkg::REG_LOCAL_FACTOR: local_factor_q <= pwdata[7:0];
        psd3_pkg::REG_Z_LIMIT:      z_limit_q      <= pwdata[7:0];
        psd3_pkg::REG_GLOBAL_FLOOR: global_floor_q <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      psd3_pkg::REG_LINE_WIDTH:   prdata = 32'(line_width_q);
      psd3_pkg::REG_LOCAL_FACTOR: prdata = 32'(local_factor_q);
      psd3_pkg::REG_Z_LIMIT:      prdata = 32'(z_limit_q);
      psd3_pkg::REG_GLOBAL_FLOOR: prdata = 32'(global_floor_q);
      default:                    prdata = '0;
    endcase
  end

  // The controller sequences each pixel; the datapath does the work.
  psd3_pkg::cmd_t    cmd;
  psd3_pkg::status_t status;

  psd3_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .in_stall_o(in_stall_o),
    .cmd_o     (cmd)
  );

  psd3_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (in_data_i),
    .line_width_i  (line_width_q),
    .local_factor_i(local_factor_q),
    .z_limit_i     (z_limit_q),
    .global_floor_i(global_floor_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
`default_nettype wire

// File: sv/psd3_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module psd3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (en_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: sv/psd3_ctrl.sv
// Controller state machine that sequences one pixel through the datapath.
`default_nettype none
module psd3_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire psd3_pkg::status_t status_i,
  output logic                   in_stall_o,
  output psd3_pkg::cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  localparam logic [4:0] STEP_LAST = 5'd16;

  state_e     state_q, state_d;
  logic [4:0] step_q, step_d;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o          = '0;
    cmd_o.op       = psd3_pkg::OP_NONE;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.shift = 1'b1;
        step_d      = '0;
        state_d     = status_i.produce ? ST_CALC : ST_IDLE;
      end
      ST_CALC: begin
        priority if (step_q == 5'd0) begin
          cmd_o.op = psd3_pkg::OP_FL;
        end else if (step_q == 5'd1) begin
          cmd_o.op = psd3_pkg::OP_FZ;
        end else if (step_q <= 5'd9) begin
          cmd_o.op  = psd3_pkg::OP_SQ;
          cmd_o.idx = 3'(step_q - 5'd2);
        end else if (step_q == 5'd10) begin
          cmd_o.op = psd3_pkg::OP_SS;
        end else if (step_q == 5'd11) begin
          cmd_o.op = psd3_pkg::OP_DD;
        end else if (step_q == 5'd12) begin
          cmd_o.op = psd3_pkg::OP_LLO;
        end else if (step_q == 5'd13) begin
          cmd_o.op = psd3_pkg::OP_LHI;
        end else if (step_q == 5'd14) begin
          cmd_o.op = psd3_pkg::OP_ZLO;
        end else if (step_q == 5'd15) begin
          cmd_o.op = psd3_pkg::OP_ZHI;
        end else begin
          cmd_o.op = psd3_pkg::OP_NONE;
        end
        step_d = step_q + 5'd1;
        if (step_q == STEP_LAST) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/psd3_dp.sv
// Datapath: column tracking, line stores, window, shared multiplier and result register.
`default_nettype none
module psd3_dp #(
  parameter int unsigned MAX_WIDTH = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire psd3_pkg::cmd_t      cmd_i,
  output psd3_pkg::status_t        status_o,
  input  wire psd3_pkg::pixel_in_t in_data_i,
  input  wire logic [8:0]          line_width_i,
  input  wire logic [7:0]          local_factor_i,
  input  wire logic [7:0]          z_limit_i,
  input  wire logic [15:0]         global_floor_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output psd3_pkg::result_t        out_data_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned MW = psd3_pkg::MUL_W;

  // Column and row tracking.
  logic [CW-1:0] w_eff, col_q, col_d, c_new, cur_c_q;
  logic [1:0]    row_q, row_d, row_new;
  logic          produce_q;
  logic [15:0]   px_q;

  always_comb begin
    if (line_width_i < 9'd3) begin
      w_eff = CW'(3);
    end else if (32'(line_width_i) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(line_width_i);
    end
  end

  always_comb begin
    if (in_data_i.frame_start) begin
      c_new   = '0;
      row_new = '0;
    end else if (col_q >= w_eff) begin
      c_new   = '0;
      row_new = (row_q == 2'd2) ? 2'd2 : row_q + 2'd1;
    end else begin
      c_new   = col_q;
      row_new = row_q;
    end
    if (32'(c_new) + 32'd1 >= 32'(w_eff)) begin
      col_d = '0;
      row_d = (row_new == 2'd2) ? 2'd2 : row_new + 2'd1;
    end else begin
      col_d = CW'(32'(c_new) + 32'd1);
      row_d = row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      produce_q <= 1'b0;
    end else if (cmd_i.accept) begin
      col_q     <= col_d;
      row_q     <= row_d;
      produce_q <= (row_new == 2'd2) && (c_new >= CW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_c_q <= c_new;
      px_q    <= in_data_i.pixel;
    end
  end

  // Line stores: a holds the previous row, b the row before it.
  logic [AW-1:0] ram_addr;
  logic [15:0]   rd_a, rd_b;

  assign ram_addr = cmd_i.accept ? c_new[AW-1:0] : cur_c_q[AW-1:0];

  psd3_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i  (clk_i),
    .en_i   (cmd_i.accept),
    .we_i   (cmd_i.shift),
    .addr_i (ram_addr),
    .wdata_i(px_q),
    .rdata_o(rd_a)
  );

  psd3_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i  (clk_i),
    .en_i   (cmd_i.accept),
    .we_i   (cmd_i.shift),
    .addr_i (ram_addr),
    .wdata_i(rd_a),
    .rdata_o(rd_b)
  );

  // 3x3 window, newest column at positions 2, 5 and 8.
  logic [15:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3+0] <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= rd_b;
      win_q[5] <= rd_a;
      win_q[8] <= px_q;
    end
  end

  // Neighbour sum and centre deviation D = 32*centre - 4*S.
  logic [18:0] nsum;
  logic [22:0] dev;
  logic        dev_pos;

  always_comb begin
    nsum = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nsum = nsum + 19'(win_q[k]);
      end
    end
    dev     = {2'b00, win_q[4], 5'b0} - {2'b00, nsum, 2'b0};
    dev_pos = !dev[22] && (dev != '0);
  end

  // Shared multiplier, registered product; the operation is registered alongside it.
  logic [MW-1:0]   mul_a, mul_b;
  logic [2*MW-1:0] prod_q;
  psd3_pkg::op_e   op_q;
  logic [15:0]     fl2_q, fz2_q;
  logic [34:0]     q_q, plo_q;
  logic [37:0]     v_q;
  logic [41:0]     dd_q;
  logic [53:0]     fv;
  logic            loc_q, hyb_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      psd3_pkg::OP_FL: begin
        mul_a = MW'(local_factor_i);
        mul_b = MW'(local_factor_i);
      end
      psd3_pkg::OP_FZ: begin
        mul_a = MW'(z_limit_i);
        mul_b = MW'(z_limit_i);
      end
      psd3_pkg::OP_SQ: begin
        mul_a = MW'(win_q[psd3_pkg::nb_pos(cmd_i.idx)]);
        mul_b = MW'(win_q[psd3_pkg::nb_pos(cmd_i.idx)]);
      end
      psd3_pkg::OP_SS: begin
        mul_a = MW'(nsum);
        mul_b = MW'(nsum);
      end
      psd3_pkg::OP_DD: begin
        mul_a = MW'(dev[20:0]);
        mul_b = MW'(dev[20:0]);
      end
      psd3_pkg::OP_LLO: begin
        mul_a = MW'(fl2_q);
        mul_b = MW'(v_q[18:0]);
      end
      psd3_pkg::OP_LHI: begin
        mul_a = MW'(fl2_q);
        mul_b = MW'(v_q[37:19]);
      end
      psd3_pkg::OP_ZLO: begin
        mul_a = MW'(fz2_q);
        mul_b = MW'(v_q[18:0]);
      end
      psd3_pkg::OP_ZHI: begin
        mul_a = MW'(fz2_q);
        mul_b = MW'(v_q[37:19]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign fv = {prod_q[34:0], 19'b0} + 54'(plo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= psd3_pkg::OP_NONE;
    end else begin
      op_q <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.shift) begin
      q_q <= '0;
    end
    unique case (op_q)
      psd3_pkg::OP_FL:  fl2_q <= prod_q[15:0];
      psd3_pkg::OP_FZ:  fz2_q <= prod_q[15:0];
      psd3_pkg::OP_SQ:  q_q   <= q_q + 35'(prod_q[31:0]);
      psd3_pkg::OP_SS:  v_q   <= {q_q, 3'b0} - prod_q[37:0];
      psd3_pkg::OP_DD:  dd_q  <= prod_q[41:0];
      psd3_pkg::OP_LLO: plo_q <= prod_q[34:0];
      psd3_pkg::OP_LHI: loc_q <= dev_pos && (54'(dd_q) > fv);
      psd3_pkg::OP_ZLO: plo_q <= prod_q[34:0];
      psd3_pkg::OP_ZHI: hyb_q <= dev_pos && (win_q[4] >= global_floor_i) && (54'(dd_q) > fv);
      default: begin
      end
    endcase
  end

  // Result register.
  logic              out_valid_q;
  psd3_pkg::result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.center_column <= 8'(32'(cur_c_q) - 32'd1);
      out_q.local_spike   <= loc_q;
      out_q.hybrid_spike  <= hyb_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.produce  = produce_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule
`default_nettype wire

// File: sv/psd3_checker.sv
// Port-level checker for the spike detector and its bind to the top level.
`default_nettype none
module psd3_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire psd3_pkg::result_t out_data_o,
  input wire logic              pready
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // One pixel at a time: an accepted request stalls the input next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A new result is only loaded while the input side is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // The configuration port never waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind pixel_spike_detect_3x3 psd3_checker u_psd3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .pready     (pready)
);
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the 3x3 pixel spike detector.
module tb_top;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // The settle time lets a pixel that classifies finish, with margin.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic                decoded_clk_unused;
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  psd3_pkg::pixel_in_t in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  psd3_pkg::result_t   out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  pixel_spike_detect_3x3 dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  assign decoded_clk_unused = clk_i;

  always #1 clk_i = ~clk_i;

  // Shadow copy of the configuration registers as the block should hold them.
  logic [8:0]  cfg_width = 9'd256;
  logic [7:0]  cfg_local = 8'd12;
  logic [7:0]  cfg_zlim = 8'd14;
  logic [15:0] cfg_floor = 16'd0;

  // Predicted image state: two previous rows, the sliding window and the scan position.
  logic [15:0] row_prev[STORE_DEPTH];
  logic [15:0] row_older[STORE_DEPTH];
  logic [15:0] win[9];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  psd3_pkg::result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idle control: quiet_mode switches off all random gaps and stalls on both sides.
  bit          quiet_mode = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      row_prev[i] = '0;
      row_older[i] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      win[i] = '0;
    end
  end

  // True when the squared deviation beats the squared factor times the scaled variance.
  function automatic bit beats_spread(input longint unsigned dev, input longint unsigned var8,
                                      input logic [7:0] factor);
    longint unsigned f2;
    f2 = longint'(factor) * longint'(factor);
    return dev * dev > f2 * var8;
  endfunction

  // Advances the predicted scan by one pixel and queues the classification it yields.
  task automatic track_pixel(input logic [15:0] px, input logic fs);
    int unsigned       w;
    int unsigned       c;
    logic [15:0]       top;
    logic [15:0]       mid;
    longint unsigned   sum;
    longint unsigned   sq;
    longint unsigned   var8;
    longint            dev;
    longint unsigned   centre;
    psd3_pkg::result_t res;
    w = cfg_width;
    if (w < 3) begin
      w = 3;
    end
    if (w > STORE_DEPTH) begin
      w = STORE_DEPTH;
    end
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos >= w) begin
      // The width shrank under the current column, so this pixel opens a new row.
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end
    c = col_pos;
    top = row_older[c];
    mid = row_prev[c];
    row_older[c] = mid;
    row_prev[c] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (row_pos >= 2 && c >= 2) begin
      sum = 0;
      sq = 0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          sum += win[k];
          sq += longint'(win[k]) * longint'(win[k]);
        end
      end
      centre = win[4];
      var8 = 8 * sq - sum * sum;
      dev = longint'(32 * centre) - longint'(4 * sum);
      res.center_column = 8'(c - 1);
      res.local_spike = 1'b0;
      res.hybrid_spike = 1'b0;
      // A flat neighborhood (zero variance) flags any center above the mean.
      if (dev > 0) begin
        res.local_spike = beats_spread(dev, var8, cfg_local);
        res.hybrid_spike = (centre >= cfg_floor) && beats_spread(dev, var8, cfg_zlim);
      end
      pending_results.insert(pending_results.size(), res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < 2) row_pos++;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one pixel request, waits until it is taken, then maybe pauses.
  task automatic send_pixel(input logic [15:0] px, input logic fs);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= '{pixel: px, frame_start: fs};
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    track_pixel(px, fs);
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits for every expected result, then lets any pixel still in flight finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the end of access.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      psd3_pkg::REG_LINE_WIDTH:   cfg_width = value[8:0];
      psd3_pkg::REG_LOCAL_FACTOR: cfg_local = value[7:0];
      psd3_pkg::REG_Z_LIMIT:      cfg_zlim = value[7:0];
      psd3_pkg::REG_GLOBAL_FLOOR: cfg_floor = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [8:0] w, input logic [7:0] lf, input logic [7:0] zl,
                            input logic [15:0] fl);
    write_reg(psd3_pkg::REG_LINE_WIDTH, 32'(w));
    write_reg(psd3_pkg::REG_LOCAL_FACTOR, 32'(lf));
    write_reg(psd3_pkg::REG_Z_LIMIT, 32'(zl));
    write_reg(psd3_pkg::REG_GLOBAL_FLOOR, 32'(fl));
  endtask

  // Pixel around a level with a little noise, sometimes a spike, sometimes anything.
  function automatic logic [15:0] pick_pixel(input logic [15:0] level);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'($urandom);
    if (r < 14) return 16'(level + $urandom_range(200, 40000));
    if (r < 20) return level;
    return 16'(level + $urandom_range(0, 12));
  endfunction

  // A whole frame of rows x cols pixels, the first carrying frame_start.
  task automatic send_frame(input int unsigned rows, input int unsigned cols,
                            input logic [15:0] level);
    for (int i = 0; i < rows * cols; i++) begin
      send_pixel(pick_pixel(level), i == 0);
    end
  endtask

  // Hand-picked 3-wide frames: flat neighborhoods, extremes of the pixel range,
  // zero and maximum factors, and the floor at both ends.
  task automatic test_directed();
    set_config(9'd3, 8'd12, 8'd14, 16'd0);
    // Flat neighbors with a brighter center, then a center equal to the mean of its neighbors.
    send_pixel(16'd5, 1'b1); send_pixel(16'd5, 1'b0); send_pixel(16'd5, 1'b0);
    send_pixel(16'd5, 1'b0); send_pixel(16'd6, 1'b0); send_pixel(16'd5, 1'b0);
    send_pixel(16'd5, 1'b0); send_pixel(16'd5, 1'b0); send_pixel(16'd5, 1'b0);
    send_pixel(16'd5, 1'b0); send_pixel(16'd4, 1'b0); send_pixel(16'd5, 1'b0);
    drain();
    set_config(9'd0, 8'd0, 8'd255, 16'hFFFF);
    // Full-scale center over near-black neighbors, then a black center among mixed neighbors.
    send_pixel(16'd0, 1'b1); send_pixel(16'd0, 1'b0); send_pixel(16'd0, 1'b0);
    send_pixel(16'd0, 1'b0); send_pixel(16'hFFFF, 1'b0); send_pixel(16'd0, 1'b0);
    send_pixel(16'd0, 1'b0); send_pixel(16'd0, 1'b0); send_pixel(16'd1, 1'b0);
    send_pixel(16'hFFFF, 1'b0); send_pixel(16'd0, 1'b0); send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    drain();
  endtask

  // Widths beyond the store act as the full store; local factor at its maximum, z limit at zero.
  task automatic test_width_limits();
    set_config(9'd511, 8'd255, 8'd0, 16'd1000);
    send_frame(2, 256, 16'd900);
    for (int i = 0; i < 12; i++) send_pixel(pick_pixel(16'd900), 1'b0);
    drain();
    set_config(9'd256, 8'd4, 8'd4, 16'd0);
    send_frame(3, 256, 16'd30000);
    drain();
  endtask

  // The width shrinks below the current column mid-row; the next pixel starts a row.
  task automatic test_width_cut();
    set_config(9'd10, 8'd12, 8'd14, 16'd0);
    send_frame(3, 10, 16'd100);
    for (int i = 0; i < 6; i++) send_pixel(pick_pixel(16'd100), 1'b0);
    drain();
    write_reg(psd3_pkg::REG_LINE_WIDTH, 32'd4);
    for (int i = 0; i < 14; i++) send_pixel(pick_pixel(16'd100), 1'b0);
    drain();
  endtask

  // The receiver holds off for a long stretch while the sender streams without pause.
  task automatic test_backpressure();
    set_config(9'd6, 8'd8, 8'd10, 16'd50);
    quiet_mode = 1'b1;
    hold_request = 1'b1;
    send_frame(10, 6, 16'd60);
    quiet_mode = 1'b0;
    drain();
  endtask

  // Random frames, mostly narrow, with fresh settings between some of them and
  // an occasional stray frame_start partway through a frame.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned cols;
    int unsigned rows;
    int unsigned r;
    logic [15:0] level;
    sent = 0;
    while (sent < 500) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        r = $urandom_range(0, 99);
        if (r < 75) cols = $urandom_range(3, 12);
        else if (r < 97) cols = $urandom_range(13, 40);
        else cols = 256;
        set_config(9'(cols), 8'($urandom_range(0, 24)), 8'($urandom_range(0, 24)),
                   16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200)));
      end else begin
        cols = cfg_width < 3 ? 3 : (cfg_width > 256 ? 256 : cfg_width);
      end
      quiet_mode = ($urandom_range(0, 5) == 0);
      rows = cols > 40 ? 3 : $urandom_range(3, 7);
      level = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300));
      for (int i = 0; i < rows * cols; i++) begin
        send_pixel(pick_pixel(level), i == 0 || $urandom_range(0, 199) == 0);
      end
      sent += rows * cols;
    end
    quiet_mode = 1'b0;
  endtask

  // Result stall: random bursts, or a long hold when the pressure test asks for one.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left <= pick_idle();
      out_stall_i <= 1'b0;
    end
  end

  // Each result request taken is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        fail_count++;
      end else begin
        psd3_pkg::result_t want;
        want = pending_results.pop_front();
        if (out_data_o.center_column !== want.center_column) begin
          $display("%0t: center_column expected %0d got %0d", $time,
                   want.center_column, out_data_o.center_column);
          fail_count++;
        end
        if (out_data_o.local_spike !== want.local_spike) begin
          $display("%0t: local_spike expected %0b got %0b (column %0d)", $time,
                   want.local_spike, out_data_o.local_spike, want.center_column);
          fail_count++;
        end
        if (out_data_o.hybrid_spike !== want.hybrid_spike) begin
          $display("%0t: hybrid_spike expected %0b got %0b (column %0d)", $time,
                   want.hybrid_spike, out_data_o.hybrid_spike, want.center_column);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL pixel_spike_detect_3x3");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_width_cut();
    test_backpressure();
    test_width_limits();
    test_random_frames();
    drain();
    if (fail_count == 0) begin
      $display("PASS pixel_spike_detect_3x3");
    end else begin
      $display("FAIL pixel_spike_detect_3x3");
    end
    $finish;
  end

endmodule

// File: pixel_spike_detect_3x3.f
sv/psd3_pkg.sv
sv/psd3_ram.sv
sv/psd3_ctrl.sv
sv/psd3_dp.sv
sv/pixel_spike_detect_3x3.sv
sv/psd3_checker.sv
bench/tb_top.sv
